// ===== rtl/core/rbf_pkg.sv =====
// rbf_pkg: shared widths, constants, register indexes and cell payload types
// for the radial bloom falloff block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

    localparam int COORD_X_W = 11;
    localparam int COORD_Y_W = 10;
    localparam int RADIUS_W  = 10;
    localparam int ALPHA_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    // squared distance of an inside pixel is below 1023^2
    localparam int RAD_W      = 2 * RADIUS_W;
    localparam int ROOT_W     = RADIUS_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SQRT_STEPS = ROOT_W;

    // quotient bits and fade * scale width
    localparam int QUO_W     = ALPHA_W;
    localparam int DIVIDEND_W = RADIUS_W + 7;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'd180;
    localparam logic [6:0]         FADE_SCALE = 7'd120;

    // r / 3 == (r * 683) >> 11 for every 10-bit r
    localparam logic [9:0] THIRD_RECIP = 10'd683;
    localparam int         THIRD_SHIFT = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_GLOW_RADIUS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              valid;
        logic              in_glow;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_cell_t;

    typedef struct packed {
        logic                valid;
        logic                in_glow;
        logic                full;
        logic [QUO_W-1:0]    low;
        logic [RADIUS_W-1:0] rem;
        logic [RADIUS_W-1:0] divisor;
        logic [QUO_W-1:0]    quo;
    } div_cell_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbf_sqrt_cell.sv =====
// rbf_sqrt_cell: one restoring square root step, two radicand bits per cell.
// Depends on rbf_pkg for the cell payload type.
`timescale 1ns / 1ps
`default_nettype none

module rbf_sqrt_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  rbf_pkg::sqrt_cell_t cell_in,
    output rbf_pkg::sqrt_cell_t cell_out
);

    rbf_pkg::sqrt_cell_t cell_reg;
    rbf_pkg::sqrt_cell_t cell_next;

    logic [rbf_pkg::REM_W+1:0] rem_sh;
    logic [rbf_pkg::REM_W+1:0] trial;

    always_comb begin
        rem_sh    = {cell_in.rem, cell_in.rad[rbf_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, cell_in.root, 2'b01};
        cell_next = cell_in;
        cell_next.rad = {cell_in.rad[rbf_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem  = rbf_pkg::REM_W'(rem_sh - trial);
            cell_next.root = {cell_in.root[rbf_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh[rbf_pkg::REM_W-1:0];
            cell_next.root = {cell_in.root[rbf_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= cell_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg.in_glow <= cell_next.in_glow;
            cell_reg.rad     <= cell_next.rad;
            cell_reg.rem     <= cell_next.rem;
            cell_reg.root    <= cell_next.root;
        end
    end

    assign cell_out = cell_reg;

`ifndef ASSERT_OFF
    // remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_reg.valid |-> ({1'b0, cell_reg.rem} <= {cell_reg.root, 1'b0}))
        else $error("sqrt cell remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rbf_div_cell.sv =====
// rbf_div_cell: one restoring division step, one quotient bit per cell.
// Depends on rbf_pkg for the cell payload type.
`timescale 1ns / 1ps
`default_nettype none

module rbf_div_cell (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                en,
    input  rbf_pkg::div_cell_t cell_in,
    output rbf_pkg::div_cell_t cell_out
);

    rbf_pkg::div_cell_t cell_reg;
    rbf_pkg::div_cell_t cell_next;

    logic [rbf_pkg::RADIUS_W:0] trial;

    always_comb begin
        trial     = {cell_in.rem, cell_in.low[rbf_pkg::QUO_W-1]};
        cell_next = cell_in;
        cell_next.low = {cell_in.low[rbf_pkg::QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, cell_in.divisor}) begin
            cell_next.rem = rbf_pkg::RADIUS_W'(trial - {1'b0, cell_in.divisor});
            cell_next.quo = {cell_in.quo[rbf_pkg::QUO_W-2:0], 1'b1};
        end else begin
            cell_next.rem = trial[rbf_pkg::RADIUS_W-1:0];
            cell_next.quo = {cell_in.quo[rbf_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= cell_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg.in_glow <= cell_next.in_glow;
            cell_reg.full    <= cell_next.full;
            cell_reg.low     <= cell_next.low;
            cell_reg.rem     <= cell_next.rem;
            cell_reg.divisor <= cell_next.divisor;
            cell_reg.quo     <= cell_next.quo;
        end
    end

    assign cell_out = cell_reg;

`ifndef ASSERT_OFF
    // in the fade region the partial remainder stays below the divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_reg.valid && cell_reg.in_glow && !cell_reg.full)
            |-> (cell_reg.rem < cell_reg.divisor))
        else $error("div cell remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/radial_bloom_falloff_alpha.sv =====
// radial_bloom_falloff_alpha: glow alpha for one pixel coordinate per request.
// Accepts one pixel per clock and passes each result through three distance
// stages, ten square root cells, one falloff setup stage, eight divider cells
// and the output register. The whole pipeline advances together
// and holds while a finished result waits on m_ready, so throughput is one
// request per cycle whenever the result side keeps up. The radius is read at
// two stages, so write the configuration only while no request is in flight.
// Depends on rbf_pkg, rbf_sqrt_cell and rbf_div_cell.
`timescale 1ns / 1ps
`default_nettype none

module radial_bloom_falloff_alpha (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_we,
    input  wire  [rbf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [rbf_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [rbf_pkg::COORD_X_W-1:0]       s_pixel_x,
    input  wire  [rbf_pkg::COORD_Y_W-1:0]       s_pixel_y,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic                                m_inside_res,
    output logic [rbf_pkg::ALPHA_W-1:0]         m_intensity
);

    // configuration
    logic [rbf_pkg::COORD_X_W-1:0] center_x_reg;
    logic [rbf_pkg::COORD_Y_W-1:0] center_y_reg;
    logic [rbf_pkg::RADIUS_W-1:0]  radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= rbf_pkg::RADIUS_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                rbf_pkg::REG_CENTER_X: begin
                    center_x_reg <= cfg_data[rbf_pkg::COORD_X_W-1:0];
                end
                rbf_pkg::REG_CENTER_Y: begin
                    center_y_reg <= cfg_data[rbf_pkg::COORD_Y_W-1:0];
                end
                rbf_pkg::REG_GLOW_RADIUS: begin
                    radius_reg <= cfg_data[rbf_pkg::RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 0: absolute differences
    logic                          v0_reg;
    logic [rbf_pkg::COORD_X_W-1:0] dx_reg, dx_next;
    logic [rbf_pkg::COORD_Y_W-1:0] dy_reg, dy_next;

    always_comb begin
        dx_next = (s_pixel_x >= center_x_reg) ? s_pixel_x - center_x_reg
                                              : center_x_reg - s_pixel_x;
        dy_next = (s_pixel_y >= center_y_reg) ? s_pixel_y - center_y_reg
                                              : center_y_reg - s_pixel_y;
    end

    // stage 1: squares
    logic                              v1_reg;
    logic [2*rbf_pkg::COORD_X_W-1:0]   dxsq_reg;
    logic [2*rbf_pkg::COORD_Y_W-1:0]   dysq_reg;

    // stage 2: sum and radius compare, feeds the root chain
    logic [2*rbf_pkg::COORD_X_W:0]     dist_sq;
    logic [rbf_pkg::RAD_W-1:0]         r_sq;
    logic                              inside_next;
    rbf_pkg::sqrt_cell_t               sq_in_reg, sq_in_next;

    always_comb begin
        dist_sq     = {1'b0, dxsq_reg} + {3'b000, dysq_reg};
        r_sq        = radius_reg * radius_reg;
        inside_next = dist_sq < {3'b000, r_sq};
        sq_in_next.valid   = v1_reg;
        sq_in_next.in_glow = inside_next;
        sq_in_next.rad     = inside_next ? dist_sq[rbf_pkg::RAD_W-1:0] : '0;
        sq_in_next.rem     = '0;
        sq_in_next.root    = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            sq_in_reg.valid <= 1'b0;
        end else if (adv) begin
            v0_reg          <= s_valid;
            v1_reg          <= v0_reg;
            sq_in_reg.valid <= sq_in_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg            <= dx_next;
            dy_reg            <= dy_next;
            dxsq_reg          <= dx_reg * dx_reg;
            dysq_reg          <= dy_reg * dy_reg;
            sq_in_reg.in_glow <= sq_in_next.in_glow;
            sq_in_reg.rad     <= sq_in_next.rad;
            sq_in_reg.rem     <= sq_in_next.rem;
            sq_in_reg.root    <= sq_in_next.root;
        end
    end

    // square root chain
    rbf_pkg::sqrt_cell_t sq_chain [0:rbf_pkg::SQRT_STEPS];
    assign sq_chain[0] = sq_in_reg;

    for (genvar i = 0; i < rbf_pkg::SQRT_STEPS; i++) begin : g_sqrt
        rbf_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .cell_in  (sq_chain[i]),
            .cell_out (sq_chain[i+1])
        );
    end

    // falloff setup: third of radius, fade, range and scaled dividend
    rbf_pkg::sqrt_cell_t               sq_out;
    logic [2*rbf_pkg::RADIUS_W-1:0]    third_prod;
    logic [rbf_pkg::RADIUS_W-1:0]      third;
    logic [rbf_pkg::RADIUS_W-1:0]      fade;
    logic [rbf_pkg::RADIUS_W-1:0]      span;
    logic [rbf_pkg::DIVIDEND_W-1:0]    dividend;
    rbf_pkg::div_cell_t                div_in_reg, div_in_next;

    always_comb begin
        sq_out     = sq_chain[rbf_pkg::SQRT_STEPS];
        third_prod = radius_reg * rbf_pkg::THIRD_RECIP;
        third      = rbf_pkg::RADIUS_W'(third_prod >> rbf_pkg::THIRD_SHIFT);
        fade       = radius_reg - sq_out.root;
        span       = radius_reg - third;
        if (span == '0) begin
            span = rbf_pkg::RADIUS_W'(1);
        end
        dividend   = fade * rbf_pkg::FADE_SCALE;
        div_in_next.valid   = sq_out.valid;
        div_in_next.in_glow = sq_out.in_glow;
        div_in_next.full    = sq_out.root < third;
        div_in_next.low     = dividend[rbf_pkg::QUO_W-1:0];
        div_in_next.rem     = {1'b0, dividend[rbf_pkg::DIVIDEND_W-1:rbf_pkg::QUO_W]};
        div_in_next.divisor = span;
        div_in_next.quo     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_in_reg.valid <= 1'b0;
        end else if (adv) begin
            div_in_reg.valid <= div_in_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_in_reg.in_glow <= div_in_next.in_glow;
            div_in_reg.full    <= div_in_next.full;
            div_in_reg.low     <= div_in_next.low;
            div_in_reg.rem     <= div_in_next.rem;
            div_in_reg.divisor <= div_in_next.divisor;
            div_in_reg.quo     <= div_in_next.quo;
        end
    end

    // divider chain
    rbf_pkg::div_cell_t div_chain [0:rbf_pkg::DIV_STEPS];
    assign div_chain[0] = div_in_reg;

    for (genvar j = 0; j < rbf_pkg::DIV_STEPS; j++) begin : g_div
        rbf_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .cell_in  (div_chain[j]),
            .cell_out (div_chain[j+1])
        );
    end

    // output register
    rbf_pkg::div_cell_t            div_out;
    logic [rbf_pkg::ALPHA_W-1:0]   alpha_next;
    logic                          m_valid_reg;
    logic                          m_inside_reg;
    logic [rbf_pkg::ALPHA_W-1:0]   m_intensity_reg;

    always_comb begin
        div_out = div_chain[rbf_pkg::DIV_STEPS];
        if (!div_out.in_glow) begin
            alpha_next = '0;
        end else if (div_out.full || div_out.quo > rbf_pkg::FULL_ALPHA) begin
            alpha_next = rbf_pkg::FULL_ALPHA;
        end else begin
            alpha_next = div_out.quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_inside_reg    <= div_out.in_glow;
            m_intensity_reg <= alpha_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;
    assign m_intensity  = m_intensity_reg;

`ifndef ASSERT_OFF
    // outside pixels carry no glow, inside ones never exceed full alpha
    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_inside_reg && m_intensity_reg <= rbf_pkg::FULL_ALPHA)
                         || (!m_inside_reg && m_intensity_reg == '0)))
        else $error("intensity inconsistent with inside flag");

    // a zero radius admits no pixel
    a_zero_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && radius_reg == '0) |-> !m_inside_reg)
        else $error("pixel inside a zero radius");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_radial_bloom_falloff_alpha.sv =====
// tb_radial_bloom_falloff_alpha: self-checking bench for the radial glow alpha block.
// A queue-fed driver and a monitor check every result against a predictor in this file.
// Depends on rbf_pkg and radial_bloom_falloff_alpha.
`timescale 1ns / 1ps

module tb_radial_bloom_falloff_alpha;

    localparam int LATENCY = 24;
    localparam logic [rbf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [rbf_pkg::COORD_X_W-1:0] x;
        logic [rbf_pkg::COORD_Y_W-1:0] y;
    } pixel_t;

    typedef struct {
        logic                        in_glow;
        logic [rbf_pkg::ALPHA_W-1:0] alpha;
    } glow_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rbf_pkg::CFG_DAT_W-1:0]  cfg_data  = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [rbf_pkg::COORD_X_W-1:0]  s_pixel_x = '0;
    logic [rbf_pkg::COORD_Y_W-1:0]  s_pixel_y = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic                           m_inside_res;
    logic [rbf_pkg::ALPHA_W-1:0]    m_intensity;

    // glow setting as the block holds it
    logic [rbf_pkg::COORD_X_W-1:0]  glow_cx = '0;
    logic [rbf_pkg::COORD_Y_W-1:0]  glow_cy = '0;
    logic [rbf_pkg::RADIUS_W-1:0]   glow_r  = 10'd1;

    pixel_t  pixel_q[$];
    glow_t   glow_q[$];
    int      sender_idle = 0;
    int      recv_stall  = 0;
    int      mismatches  = 0;
    int      pixels_sent = 0;
    int      results_seen = 0;
    int      inside_seen = 0;
    int      settings_used = 0;

    radial_bloom_falloff_alpha i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_x    (s_pixel_x),
        .s_pixel_y    (s_pixel_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res),
        .m_intensity  (m_intensity)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic glow_t glow_of(input logic [rbf_pkg::COORD_X_W-1:0] px,
                                      input logic [rbf_pkg::COORD_Y_W-1:0] py);
        glow_t       g;
        int unsigned dx, dy, dist_sq, rad, root, trial, third, fade, span, a;
        dx      = (px >= glow_cx) ? px - glow_cx : glow_cx - px;
        dy      = (py >= glow_cy) ? py - glow_cy : glow_cy - py;
        dist_sq = dx * dx + dy * dy;
        rad     = glow_r;
        a       = 0;
        g.in_glow = 1'b0;
        if (dist_sq < rad * rad) begin
            g.in_glow = 1'b1;
            // inside means dist_sq < 2^20, so ten root bits suffice
            root = 0;
            for (int b = rbf_pkg::ROOT_W - 1; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= dist_sq) root = trial;
            end
            third = rad / 3;
            if (root < third) begin
                a = rbf_pkg::FULL_ALPHA;
            end else begin
                fade = rad - root;
                span = rad - third;
                if (span == 0) span = 1;
                a = fade * rbf_pkg::FADE_SCALE / span;
                if (a > rbf_pkg::FULL_ALPHA) a = rbf_pkg::FULL_ALPHA;
            end
        end
        g.alpha = a[rbf_pkg::ALPHA_W-1:0];
        return g;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
                s_valid   <= 1'b1;
                s_pixel_x <= pixel_q[0].x;
                s_pixel_y <= pixel_q[0].y;
                void'(pixel_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        glow_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                glow_q.push_back(glow_of(s_pixel_x, s_pixel_y));
                pixels_sent++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_inside_res) inside_seen++;
                if (glow_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result inside=%0b alpha=%0d",
                                 m_inside_res, m_intensity);
                end else begin
                    want = glow_q.pop_front();
                    if (m_inside_res !== want.in_glow || m_intensity !== want.alpha) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected inside=%0b alpha=%0d,",
                                      " got inside=%0b alpha=%0d"},
                                     want.in_glow, want.alpha, m_inside_res, m_intensity);
                    end
                end
            end
        end
    end

    task automatic program_glow(input logic [rbf_pkg::CFG_DAT_W-1:0] x,
                                input logic [rbf_pkg::CFG_DAT_W-1:0] y,
                                input logic [rbf_pkg::CFG_DAT_W-1:0] r);
        // the unused index must leave the setting alone
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= rbf_pkg::CFG_DAT_W'($urandom);
        @(posedge aclk);
        cfg_index <= rbf_pkg::REG_CENTER_X;
        cfg_data  <= x;
        @(posedge aclk);
        cfg_index <= rbf_pkg::REG_CENTER_Y;
        cfg_data  <= y;
        @(posedge aclk);
        cfg_index <= rbf_pkg::REG_GLOW_RADIUS;
        cfg_data  <= r;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        glow_cx = x;
        glow_cy = y[rbf_pkg::COORD_Y_W-1:0];
        glow_r  = r[rbf_pkg::RADIUS_W-1:0];
        settings_used++;
    endtask

    task automatic add_pixel(input int x, input int y);
        pixel_t p;
        p.x = rbf_pkg::COORD_X_W'(x);
        p.y = rbf_pkg::COORD_Y_W'(y);
        pixel_q.push_back(p);
    endtask

    // checked on the falling edge, where driver and monitor have settled
    task automatic drain();
        while (pixel_q.size() != 0 || s_valid || glow_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 6) @(posedge aclk);
    endtask

    // mostly pixels around the centre so that the falloff is exercised
    task automatic random_pixels(input int n, input int s_idle, input int r_stall);
        int span;
        sender_idle = s_idle;
        recv_stall  = r_stall;
        span = int'(glow_r) + 3;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 7)
                add_pixel(int'(glow_cx) + $urandom_range(0, 2 * span) - span,
                          int'(glow_cy) + $urandom_range(0, 2 * span) - span);
            else
                add_pixel($urandom_range(0, 2047), $urandom_range(0, 1023));
        end
        drain();
    endtask

    initial begin
        int mode;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting: centre at origin, radius one
        add_pixel(0, 0);
        add_pixel(1, 0);
        add_pixel(2047, 1023);
        drain();

        program_glow(11'd640, 11'd360, 11'd300);
        add_pixel(640, 360);
        add_pixel(739, 360);
        add_pixel(740, 360);
        add_pixel(939, 360);
        add_pixel(940, 360);
        add_pixel(640, 660);
        add_pixel(640, 61);
        add_pixel(852, 572);
        add_pixel(0, 0);
        add_pixel(2047, 1023);
        add_pixel(2047, 0);
        add_pixel(0, 1023);
        add_pixel(1279, 719);
        drain();

        // radius zero leaves nothing inside
        program_glow(11'd100, 11'd100, 11'd0);
        add_pixel(100, 100);
        add_pixel(101, 100);
        drain();

        // radius two: the inner third is empty
        program_glow(11'd5, 11'd5, 11'd2);
        add_pixel(5, 5);
        add_pixel(6, 5);
        add_pixel(6, 6);
        add_pixel(7, 5);
        drain();

        program_glow(11'd640, 11'd360, 11'd300);
        random_pixels(75, 0, 0);
        program_glow(11'd0, 11'd0, 11'd1023);
        random_pixels(75, 57, 0);
        program_glow(11'h7FF, 11'h7FF, 11'h7FF);
        random_pixels(75, 0, 57);
        program_glow(11'd1279, 11'd719, 11'd3);
        random_pixels(75, 10, 10);
        for (int k = 0; k < 3; k++) begin
            program_glow(rbf_pkg::CFG_DAT_W'($urandom), rbf_pkg::CFG_DAT_W'($urandom),
                         ($urandom_range(1) != 0)
                             ? rbf_pkg::CFG_DAT_W'($urandom_range(1, 40))
                             : rbf_pkg::CFG_DAT_W'($urandom_range(1, 1023)));
            mode = $urandom_range(3);
            random_pixels(75, (mode == 1) ? 57 : (mode == 3) ? 10 : 0,
                              (mode == 2) ? 57 : (mode == 3) ? 10 : 0);
        end

        if (glow_q.size() != 0) mismatches++;
        $display("covered %0d pixels over %0d glow settings with all idle patterns",
                 pixels_sent, settings_used);
        $display("checked %0d results, %0d inside the glow", results_seen, inside_seen);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rbf_pkg.sv
rtl/core/rbf_sqrt_cell.sv
rtl/core/rbf_div_cell.sv
rtl/core/radial_bloom_falloff_alpha.sv
verif/tb_radial_bloom_falloff_alpha.sv
